[hdl/rpn_stack_evaluator_assert.svh]
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_assert
// assertion macros shared by the rpn evaluator modules
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RPN_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// implication checked in the cycle after
`define RPN_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

[hdl/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// rpn_pkg
// shared constants and types of the postfix evaluator
// ----------------------------------------------------------------------------
`default_nettype none
package rpn_pkg;
	localparam int STACK_DEPTH = 64;
	localparam int PTR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W = 32;

	localparam logic [3:0] ACT_PUSH = 4'd0;
	localparam logic [3:0] ACT_ADD  = 4'd1;
	localparam logic [3:0] ACT_SUB  = 4'd2;
	localparam logic [3:0] ACT_MUL  = 4'd3;
	localparam logic [3:0] ACT_DIV  = 4'd4;
	localparam logic [3:0] ACT_POW  = 4'd5;
	localparam logic [3:0] ACT_LOG  = 4'd6;
	localparam logic [3:0] ACT_SQRT = 4'd7;
	localparam logic [3:0] ACT_TERN = 4'd8;
	localparam logic [3:0] ACT_EOL  = 4'd9;

	// request to the iterative arithmetic unit
	typedef struct packed {
		logic        go;
		logic [3:0]  op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic        err;
		logic [31:0] res;
	} alu_rsp_t;
endpackage
`default_nettype wire

[hdl/rpn_alu.sv]
// ----------------------------------------------------------------------------
// rpn_alu
// multicycle arithmetic: add, sub, mul, div, pow, log, sqrt
// ----------------------------------------------------------------------------
`default_nettype none
`include "rpn_stack_evaluator_assert.svh"
module rpn_alu (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rpn_pkg::alu_req_t req,
	output rpn_pkg::alu_rsp_t     rsp
);
	typedef enum logic [2:0] {A_IDLE, A_DIV, A_POW, A_LOG, A_SQRT, A_DONE} astate_t;
	astate_t st_q;
	logic [31:0] a_q, b_q, acc_q, rem_q, quo_q, res_q;
	logic [63:0] p_q;
	logic [5:0] cnt_q;
	logic neg_q, err_q;
	logic [32:0] rem_sh;
	logic [15:0] sq_t;
	logic [31:0] sq_p;
	logic [63:0] lg_p;
	logic [3:0] op_q;

	assign rem_sh = {rem_q, quo_q[31]};
	assign sq_t = res_q[15:0] | (16'd1 << cnt_q[3:0]);
	assign sq_p = {16'd0, sq_t} * {16'd0, sq_t};
	assign lg_p = p_q[31:0] * b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
			cnt_q <= '0;
			err_q <= 1'b0;
		end else begin
			case (st_q)
			A_IDLE: begin
				if (req.go) begin
					a_q <= req.a;
					b_q <= (req.op == rpn_pkg::ACT_DIV && req.b[31]) ? 32'd0 - req.b : req.b;
					case (req.op)
					rpn_pkg::ACT_ADD: begin
						res_q <= req.a + req.b;
						err_q <= 1'b0;
						st_q <= A_DONE;
					end
					rpn_pkg::ACT_SUB: begin
						res_q <= req.a - req.b;
						err_q <= 1'b0;
						st_q <= A_DONE;
					end
					rpn_pkg::ACT_MUL: begin
						res_q <= req.a * req.b;
						err_q <= 1'b0;
						st_q <= A_DONE;
					end
					rpn_pkg::ACT_DIV: begin
						if (req.b == '0) begin
							err_q <= 1'b1;
							st_q <= A_DONE;
						end else begin
							quo_q <= req.a[31] ? 32'd0 - req.a : req.a;
							neg_q <= req.a[31] ^ req.b[31];
							rem_q <= '0;
							cnt_q <= 6'd32;
							err_q <= 1'b0;
							st_q <= A_DIV;
						end
					end
					rpn_pkg::ACT_POW: begin
						if (req.b[31]) begin
							err_q <= 1'b1;
							st_q <= A_DONE;
						end else begin
							acc_q <= 32'd1;
							err_q <= 1'b0;
							st_q <= A_POW;
						end
					end
					rpn_pkg::ACT_LOG: begin
						if ($signed(req.b) <= 32'sd1 || $signed(req.a) <= 32'sd0) begin
							err_q <= 1'b1;
							st_q <= A_DONE;
						end else begin
							p_q <= {32'd0, req.b};
							acc_q <= '0;
							err_q <= 1'b0;
							st_q <= A_LOG;
						end
					end
					rpn_pkg::ACT_SQRT: begin
						if (req.a[31]) begin
							err_q <= 1'b1;
							st_q <= A_DONE;
						end else begin
							res_q <= '0;
							cnt_q <= 6'd15;
							err_q <= 1'b0;
							st_q <= A_SQRT;
						end
					end
					default: begin err_q <= 1'b1; st_q <= A_DONE; end
					endcase
				end else begin
					err_q <= 1'b0;
				end
			end
			A_DIV: begin
				// restoring division, one quotient bit a cycle
				if (rem_sh >= {1'b0, b_q}) begin
					rem_q <= 32'(rem_sh - {1'b0, b_q});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) st_q <= A_DONE;
			end
			A_POW: begin
				// square and multiply, one exponent bit a cycle
				if (b_q[0]) acc_q <= acc_q * a_q;
				a_q <= a_q * a_q;
				b_q <= b_q >> 1;
				if (b_q[31:1] == '0) st_q <= A_DONE;
			end
			A_LOG: begin
				// p stays below 2^62 since base and argument are under 2^31
				if (p_q <= {32'd0, a_q}) begin
					acc_q <= acc_q + 32'd1;
					p_q <= lg_p;
				end else begin
					st_q <= A_DONE;
				end
			end
			A_SQRT: begin
				if (sq_p <= a_q) res_q <= {16'd0, sq_t};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) st_q <= A_DONE;
			end
			A_DONE: st_q <= A_IDLE;
			default: st_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == A_IDLE && req.go) op_q <= req.op;
	end

	// final result selection from the working registers
	always_comb begin
		rsp.done = (st_q == A_DONE);
		rsp.err = err_q;
		case (op_q)
		rpn_pkg::ACT_DIV:  rsp.res = neg_q ? 32'd0 - quo_q : quo_q;
		rpn_pkg::ACT_POW:  rsp.res = acc_q;
		rpn_pkg::ACT_LOG:  rsp.res = acc_q;
		default:           rsp.res = res_q;
		endcase
	end

	`RPN_ASSERT_IMP(a_div_nz, clk, arst_n, st_q == A_DIV, b_q != '0)
	`RPN_ASSERT_NEXT(a_done_once, clk, arst_n, st_q == A_DONE, st_q == A_IDLE)
	`RPN_ASSERT_IMP(a_sqrt_cnt, clk, arst_n, st_q == A_SQRT, cnt_q <= 6'd15)
endmodule
`default_nettype wire

[hdl/rpn_ctrl.sv]
// ----------------------------------------------------------------------------
// rpn_ctrl
// token sequencer over the stack memory
// ----------------------------------------------------------------------------
`default_nettype none
`include "rpn_stack_evaluator_assert.svh"
module rpn_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [3:0]        action,
	input  wire logic signed [31:0] value,
	output logic                   busy,
	output logic                   done,
	output logic signed [31:0]     result_value,
	output logic                   line_error,
	output rpn_pkg::alu_req_t      areq,
	input  wire rpn_pkg::alu_rsp_t arsp
);
	typedef enum logic [2:0] {S_IDLE, S_RD, S_WAIT, S_CALC, S_ALU, S_WR} cstate_t;
	cstate_t st_q;
	logic [31:0] mem [rpn_pkg::STACK_DEPTH];
	logic [31:0] rd_q;
	logic [rpn_pkg::PTR_W-1:0] ra_q;
	logic [rpn_pkg::CNT_W-1:0] cnt_q;
	logic err_q;
	logic [3:0] act_q;
	logic [1:0] need_q, got_q;
	logic [31:0] op0_q, op1_q, wv_q;
	logic we;
	logic [rpn_pkg::PTR_W-1:0] wa;
	logic eol_bad, eol_ok, go_d;

	// synchronous stack memory, registered read
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wv_q;
		rd_q <= mem[ra_q];
	end
	assign we = (st_q == S_WR);
	assign wa = cnt_q[rpn_pkg::PTR_W-1:0];
	assign busy = (st_q != S_IDLE);

	assign eol_bad = (st_q == S_IDLE) && start && (action == rpn_pkg::ACT_EOL) &&
		(err_q || cnt_q != rpn_pkg::CNT_W'(1));
	assign eol_ok = (st_q == S_CALC) && (act_q == rpn_pkg::ACT_EOL);
	// last operand captured, hand the operator to the arithmetic unit
	assign go_d = (st_q == S_CALC) && (act_q != rpn_pkg::ACT_EOL) &&
		(act_q != rpn_pkg::ACT_TERN) && (got_q + 2'd1 == need_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			err_q <= 1'b0;
			done <= 1'b0;
			line_error <= 1'b0;
			result_value <= '0;
			areq <= '0;
			got_q <= '0;
		end else begin
			done <= eol_bad || eol_ok;
			areq.go <= go_d;
			case (st_q)
			S_IDLE: begin
				if (start) begin
					act_q <= action;
					got_q <= '0;
					ra_q <= '0;
					if (action == rpn_pkg::ACT_EOL) begin
						if (!err_q && cnt_q == rpn_pkg::CNT_W'(1)) begin
							st_q <= S_RD;
							need_q <= 2'd0;
						end else begin
							line_error <= 1'b1;
							result_value <= '0;
							cnt_q <= '0;
							err_q <= 1'b0;
						end
					end else if (err_q) begin
					end else if (action == rpn_pkg::ACT_PUSH) begin
						if (cnt_q >= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH)) err_q <= 1'b1;
						else begin wv_q <= value; st_q <= S_WR; end
					end else if (action >= rpn_pkg::ACT_ADD && action <= rpn_pkg::ACT_TERN) begin
						need_q <= action == rpn_pkg::ACT_TERN ? 2'd3 :
							action == rpn_pkg::ACT_SQRT ? 2'd1 : 2'd2;
						st_q <= S_RD;
					end else begin
						err_q <= 1'b1;
					end
				end
			end
			S_RD: begin
				if (need_q == 2'd0) begin
					ra_q <= '0;
					st_q <= S_WAIT;
				end else if (cnt_q == '0) begin
					err_q <= 1'b1;
					st_q <= S_IDLE;
				end else begin
					ra_q <= rpn_pkg::PTR_W'(cnt_q - rpn_pkg::CNT_W'(1));
					cnt_q <= cnt_q - rpn_pkg::CNT_W'(1);
					st_q <= S_WAIT;
				end
			end
			S_WAIT: st_q <= S_CALC;
			S_CALC: begin
				if (act_q == rpn_pkg::ACT_EOL) begin
					line_error <= 1'b0;
					result_value <= rd_q;
					cnt_q <= '0;
					st_q <= S_IDLE;
				end else begin
					// operands arrive top first
					case (got_q)
					2'd0: op0_q <= rd_q;
					2'd1: op1_q <= rd_q;
					default: begin end
					endcase
					got_q <= got_q + 2'd1;
					if (got_q + 2'd1 == need_q) begin
						if (act_q == rpn_pkg::ACT_TERN) begin
							wv_q <= rd_q != '0 ? op1_q : op0_q;
							st_q <= S_WR;
						end else begin
							areq.op <= act_q;
							areq.a <= got_q == 2'd0 ? rd_q : op0_q;
							areq.b <= rd_q;
							st_q <= S_ALU;
						end
					end else begin
						st_q <= S_RD;
					end
				end
			end
			S_ALU: begin
				if (arsp.done) begin
					if (arsp.err) begin
						err_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						wv_q <= arsp.res;
						st_q <= S_WR;
					end
				end
			end
			S_WR: begin
				cnt_q <= cnt_q + rpn_pkg::CNT_W'(1);
				st_q <= S_IDLE;
			end
			default: st_q <= S_IDLE;
			endcase
		end
	end

	`RPN_ASSERT_IMP(c_cnt_max, clk, arst_n, 1'b1, cnt_q <= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
	`RPN_ASSERT_IMP(c_wr_room, clk, arst_n, we, cnt_q < rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
	`RPN_ASSERT_NEXT(c_done_idle, clk, arst_n, done, !$past(busy) || st_q == S_IDLE)
endmodule
`default_nettype wire

[hdl/rpn_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// postfix integer evaluator over a 64-entry stack memory
// ----------------------------------------------------------------------------
// usage: drive action and value and raise start; the token is taken at a
// rising edge with start high and busy low. operator tokens pop operands from
// the stack memory one per pass (read, wait, capture), then run in the
// arithmetic unit and push back; the ternary selects without that unit.
// an end-of-line token raises done for one cycle with result_value and
// line_error; the receiver cannot stall and must take it in that cycle. for
// a good line done is registered after the read, wait and capture states,
// for a bad one in the cycle after the token is taken. after an error,
// tokens are dropped until end of line. reset clears the count and error
// flag; memory content is left undefined.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_stack_evaluator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [3:0]         action,
	input  wire logic signed [31:0] value,
	output logic                    busy,
	output logic                    done,
	output logic signed [31:0]      result_value,
	output logic                    line_error
);
	rpn_pkg::alu_req_t areq;
	rpn_pkg::alu_rsp_t arsp;

	rpn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action), .value(value),
		.busy(busy), .done(done), .result_value(result_value),
		.line_error(line_error), .areq(areq), .arsp(arsp)
	);

	rpn_alu u_alu (.clk(clk), .arst_n(arst_n), .req(areq), .rsp(arsp));
endmodule
`default_nettype wire

[tb/rpn_stack_evaluator_test.sv]
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_test
// self-checking bench: directed and random postfix lines are fed to the
// evaluator, a scoreboard predicts each end-of-line result and checks it
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_stack_evaluator_test;
	localparam logic [3:0] ACT_BAD = 4'd10;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int unsigned ITEM_COUNT = 900;

	class line_scoreboard;
		logic [31:0] stack_mem [rpn_pkg::STACK_DEPTH];
		int unsigned depth_used;
		bit err_flag;
		logic [32:0] pending_q [$];
		int unsigned mismatches;

		function new();
			depth_used = 0;
			err_flag = 0;
			mismatches = 0;
		endfunction

		function bit pop(output logic [31:0] v);
			if (depth_used == 0) begin
				err_flag = 1;
				return 0;
			end
			depth_used--;
			v = stack_mem[depth_used];
			return 1;
		endfunction

		function void push(logic [31:0] v);
			if (depth_used >= rpn_pkg::STACK_DEPTH) begin
				err_flag = 1;
				return;
			end
			stack_mem[depth_used] = v;
			depth_used++;
		endfunction

		function logic [31:0] isqrt(logic [31:0] a);
			logic [31:0] r, t;
			r = 0;
			for (int b = 15; b >= 0; b--) begin
				t = r | (32'd1 << b);
				if (64'(t) * 64'(t) <= 64'(a))
					r = t;
			end
			return r;
		endfunction

		function logic [31:0] pow_mod(logic [31:0] bse, logic [31:0] ex);
			logic [31:0] acc;
			acc = 1;
			while (ex != 0) begin
				if (ex[0])
					acc = acc * bse;
				bse = bse * bse;
				ex = ex >> 1;
			end
			return acc;
		endfunction

		function logic [31:0] flog(logic [63:0] arg, logic [63:0] bse);
			logic [63:0] p;
			logic [31:0] c;
			p = bse;
			c = 0;
			while (p <= arg) begin
				c++;
				p = p * bse;
			end
			return c;
		endfunction

		function logic [31:0] div_tz(logic [31:0] n, logic [31:0] d);
			logic [31:0] un, ud, q;
			un = n[31] ? -n : n;
			ud = d[31] ? -d : d;
			q = un / ud;
			return (n[31] != d[31]) ? -q : q;
		endfunction

		function void note_token(logic [3:0] act, logic [31:0] val);
			logic [31:0] top, sec, third, r;
			if (act == rpn_pkg::ACT_EOL) begin
				if (!err_flag && depth_used == 1)
					pending_q.push_back({1'b0, stack_mem[0]});
				else
					pending_q.push_back({1'b1, 32'd0});
				depth_used = 0;
				err_flag = 0;
				return;
			end
			if (err_flag)
				return;
			case (act)
				rpn_pkg::ACT_PUSH: push(val);
				rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL,
				rpn_pkg::ACT_DIV, rpn_pkg::ACT_POW, rpn_pkg::ACT_LOG: begin
					if (!pop(top) || !pop(sec))
						return;
					case (act)
						rpn_pkg::ACT_ADD: r = top + sec;
						rpn_pkg::ACT_SUB: r = top - sec;
						rpn_pkg::ACT_MUL: r = top * sec;
						rpn_pkg::ACT_DIV: begin
							if (sec == 0) begin
								err_flag = 1;
								return;
							end
							r = div_tz(top, sec);
						end
						rpn_pkg::ACT_POW: begin
							if ($signed(sec) < 0) begin
								err_flag = 1;
								return;
							end
							r = pow_mod(top, sec);
						end
						default: begin
							if ($signed(sec) <= 1 || $signed(top) <= 0) begin
								err_flag = 1;
								return;
							end
							r = flog(64'(top), 64'(sec));
						end
					endcase
					push(r);
				end
				rpn_pkg::ACT_SQRT: begin
					if (!pop(top))
						return;
					if (top[31])
						err_flag = 1;
					else
						push(isqrt(top));
				end
				rpn_pkg::ACT_TERN: begin
					if (pop(third) && pop(sec) && pop(top))
						push(top != 0 ? sec : third);
				end
				default: err_flag = 1;
			endcase
		endfunction

		function void check_result(logic [31:0] val, logic err);
			logic [32:0] exp_r;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result expected none actual err=%0d value=%0d",
					$time, err, $signed(val));
				mismatches++;
				return;
			end
			exp_r = pending_q.pop_front();
			if (err !== exp_r[32]) begin
				$display("%0t: line_error mismatch expected %0d actual %0d",
					$time, exp_r[32], err);
				mismatches++;
			end
			if (val !== exp_r[31:0]) begin
				$display("%0t: result_value mismatch expected %0d actual %0d",
					$time, $signed(exp_r[31:0]), $signed(val));
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [3:0] action = 0;
	logic signed [31:0] value = 0;
	logic busy, done, line_error;
	logic signed [31:0] result_value;

	line_scoreboard sb;
	int unsigned idle_cycles = 0;
	int unsigned tokens_sent = 0;

	rpn_stack_evaluator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action), .value(value),
		.busy(busy), .done(done), .result_value(result_value), .line_error(line_error)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result_value, line_error);
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("rpn_stack_evaluator regression: fail");
			$finish;
		end
	end

	function automatic int gap_len();
		int n;
		n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 80)) :
			int'($urandom_range(0, 3));
		if ($urandom_range(0, 3) == 0)
			n = 0;
		return n;
	endfunction

	// one token per transaction, start held until accepted
	task automatic send_token(logic [3:0] act, logic [31:0] val);
		int n;
		start <= 1'b1;
		action <= act;
		value <= val;
		do @(posedge clk); while (busy);
		sb.note_token(act, val);
		tokens_sent++;
		n = gap_len();
		if (n != 0) begin
			start <= 1'b0;
			action <= 4'($urandom());
			value <= $urandom();
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending until every pending line has come back
	task automatic hold_off();
		start <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 12);
			1: return -$urandom_range(0, 4);
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_line();
		int depth, n;
		logic [3:0] op;
		depth = 0;
		n = int'($urandom_range(1, 12));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_token(4'($urandom_range(10, 15)), $urandom());
			end else if (depth < 2 || $urandom_range(0, 2) == 0) begin
				send_token(rpn_pkg::ACT_PUSH, rand_val());
				depth++;
			end else begin
				op = 4'($urandom_range(1, 8));
				if (op == rpn_pkg::ACT_TERN && depth < 3)
					op = rpn_pkg::ACT_ADD;
				send_token(op, $urandom());
				depth -= (op == rpn_pkg::ACT_SQRT) ? 0 : (op == rpn_pkg::ACT_TERN) ? 2 : 1;
			end
		end
		// mostly reduce to one entry so lines pass
		while (depth > 1 && $urandom_range(0, 4) != 0) begin
			send_token(4'($urandom_range(1, 3)), 0);
			depth--;
		end
		send_token(rpn_pkg::ACT_EOL, $urandom());
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_token(rpn_pkg::ACT_PUSH, 32'h7fff_ffff); send_token(rpn_pkg::ACT_PUSH, 1);
		send_token(rpn_pkg::ACT_ADD, 0); send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_PUSH, 5); send_token(rpn_pkg::ACT_PUSH, 3);
		send_token(rpn_pkg::ACT_SUB, 0);
		send_token(rpn_pkg::ACT_PUSH, -7); send_token(rpn_pkg::ACT_MUL, 0);
		send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_PUSH, -1); send_token(rpn_pkg::ACT_PUSH, 32'h8000_0000);
		send_token(rpn_pkg::ACT_DIV, 0); send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_PUSH, 0); send_token(rpn_pkg::ACT_PUSH, 9);
		send_token(rpn_pkg::ACT_DIV, 0);
		send_token(rpn_pkg::ACT_PUSH, 1); send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_PUSH, 31); send_token(rpn_pkg::ACT_PUSH, 2);
		send_token(rpn_pkg::ACT_POW, 0); send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_PUSH, -1); send_token(rpn_pkg::ACT_PUSH, 2);
		send_token(rpn_pkg::ACT_POW, 0); send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_PUSH, 3); send_token(rpn_pkg::ACT_PUSH, 32'h7fff_ffff);
		send_token(rpn_pkg::ACT_LOG, 0); send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_PUSH, 1); send_token(rpn_pkg::ACT_PUSH, 8);
		send_token(rpn_pkg::ACT_LOG, 0); send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_PUSH, 32'h7fff_ffff); send_token(rpn_pkg::ACT_SQRT, 0);
		send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_PUSH, -4); send_token(rpn_pkg::ACT_SQRT, 0);
		send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_PUSH, 0); send_token(rpn_pkg::ACT_PUSH, 11);
		send_token(rpn_pkg::ACT_PUSH, 22);
		send_token(rpn_pkg::ACT_TERN, 0); send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_ADD, 0); send_token(rpn_pkg::ACT_EOL, 0);
		send_token(ACT_BAD, 0); send_token(rpn_pkg::ACT_PUSH, 1);
		send_token(rpn_pkg::ACT_EOL, 0);
		send_token(4'd15, 0); send_token(rpn_pkg::ACT_EOL, 0);
		send_token(rpn_pkg::ACT_EOL, 0);
		// overflow: one push past full
		for (int i = 0; i <= rpn_pkg::STACK_DEPTH; i++)
			send_token(rpn_pkg::ACT_PUSH, $urandom());
		send_token(rpn_pkg::ACT_EOL, 0);

		// hold off until all lines have come back
		hold_off();

		while (tokens_sent < ITEM_COUNT)
			send_line();

		hold_off();
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("rpn_stack_evaluator regression: pass");
		else
			$display("rpn_stack_evaluator regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

[rpn_stack_evaluator.f]
+incdir+hdl
hdl/rpn_pkg.sv
hdl/rpn_alu.sv
hdl/rpn_ctrl.sv
hdl/rpn_stack_evaluator.sv
tb/rpn_stack_evaluator_test.sv
